// File: design/okvt_pkg.sv
// Shared constants, codes and types for the ordered key-value table.
package okvt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BEYOND  = 3'd4;

    // Broadcast command from the control to every cell of the row.
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } cell_cmd_t;

endpackage

// File: design/ordered_key_value_table_core.sv
// Top level of the ordered key-value table: request control over a row of entry cells.
//
//   beat     | signals                                        | direction
//   ---------+------------------------------------------------+----------
//   request  | in_valid, in_ready, action, key, value, position | in
//   response | out_valid, out_ready, status, found, key_out,  | out
//            | value_out, entry_count                         |
//
// Each request is first registered as a beat; then every cell compares its key
// against the request and the row is updated.
// One request is in flight at a time; the next beat is taken while the
// response still waits in its output register.
// A stalled response holds the row; rst_n clears the count and all valids.
module ordered_key_value_table_core
    import okvt_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ACTION_W-1:0] action,
    input  logic [KEY_W-1:0]    key,
    input  logic [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]    position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic                found,
    output logic [KEY_W-1:0]    key_out,
    output logic [VALUE_W-1:0]  value_out,
    output logic [COUNT_W-1:0]  entry_count
);

    localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int VW   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int PW   = (IW > POS_W) ? IW : POS_W;
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic                busy_reg;
    logic [ACTION_W-1:0] req_action_reg;
    logic [KW-1:0]       req_key_reg;
    logic [VW-1:0]       req_value_reg;
    logic [POS_W-1:0]    req_pos_reg;
    logic [CW-1:0]       count_reg, count_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                found_reg, found_next;
    logic [KEY_W-1:0]    key_out_reg, key_out_next;
    logic [VALUE_W-1:0]  value_out_reg, value_out_next;

    logic [KW-1:0]       cell_key   [CAPACITY];
    logic [VW-1:0]       cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    logic [CAPACITY:0]   hit_chain;
    cell_cmd_t           cmd;

    logic                run;
    logic                hit;
    logic                full;
    logic                pos_ok;
    logic [PW-1:0]       pos_ext;
    logic [IW-1:0]       pos_idx;
    logic [VW-1:0]       match_value;

    assign in_ready    = !busy_reg;
    assign run         = busy_reg && (!out_valid_reg || out_ready);
    assign hit_chain[0] = 1'b0;
    assign hit         = hit_chain[CAPACITY];
    assign full        = count_reg == CW'(CAPACITY);
    assign pos_ext     = PW'(req_pos_reg);
    assign pos_idx     = pos_ext[IW-1:0];
    assign pos_ok      = CMPW'(req_pos_reg) < CMPW'(count_reg);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [KW-1:0] nk;
            logic [VW-1:0] nv;
            if (g < CAPACITY - 1)
            begin : g_mid
                assign nk = cell_key[g+1];
                assign nv = cell_value[g+1];
            end
            else
            begin : g_last
                assign nk = cell_key[g];
                assign nv = cell_value[g];
            end
            okvt_cell #(
                .INDEX (g),
                .KW    (KW),
                .VW    (VW),
                .CW    (CW)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .count      (count_reg),
                .req_key    (req_key_reg),
                .req_value  (req_value_reg),
                .next_key   (nk),
                .next_value (nv),
                .hit_in     (hit_chain[g]),
                .hit_out    (hit_chain[g+1]),
                .match      (cell_match[g]),
                .key        (cell_key[g]),
                .value      (cell_value[g])
            );
        end
    endgenerate

    // Keys are unique, so an OR over the matching cells picks the one value.
    always_comb
    begin
        match_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            match_value = match_value | (cell_match[i] ? cell_value[i] : '0);
        end
    end

    always_comb
    begin
        cmd            = '0;
        count_next     = count_reg;
        status_next    = ST_DONE;
        found_next     = 1'b0;
        key_out_next   = '0;
        value_out_next = '0;
        case (req_action_reg)
            ACT_INSERT:
            begin
                if (hit)
                begin
                    status_next = ST_DUP;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.do_insert = run;
                    count_next    = count_reg + CW'(1);
                end
            end
            ACT_REMOVE:
            begin
                if (!hit)
                begin
                    status_next = ST_ABSENT;
                end
                else
                begin
                    cmd.do_remove = run;
                    count_next    = count_reg - CW'(1);
                end
            end
            ACT_LOOKUP:
            begin
                if (hit)
                begin
                    found_next     = 1'b1;
                    value_out_next = VALUE_W'(match_value);
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
            default:
            begin
                if (pos_ok)
                begin
                    found_next     = 1'b1;
                    key_out_next   = KEY_W'(cell_key[pos_idx]);
                    value_out_next = VALUE_W'(cell_value[pos_idx]);
                end
                else
                begin
                    status_next = ST_BEYOND;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
            end
            else if (run)
            begin
                busy_reg <= 1'b0;
            end
            if (run)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_action_reg <= action;
            req_key_reg    <= key[KW-1:0];
            req_value_reg  <= value[VW-1:0];
            req_pos_reg    <= position;
        end
        if (run)
        begin
            status_reg    <= status_next;
            found_reg     <= found_next;
            key_out_reg   <= key_out_next;
            value_out_reg <= value_out_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign key_out     = key_out_reg;
    assign value_out   = value_out_reg;
    // count only moves together with a new response, so it matches the held beat
    assign entry_count = COUNT_W'(count_reg);

endmodule

// File: design/okvt_cell.sv
// One entry of the table: holds a key and value, compares, and shifts toward the head.
module okvt_cell
    import okvt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int KW    = 32,
    parameter int VW    = 32,
    parameter int CW    = 5
)
(
    input  logic          clk,
    input  cell_cmd_t     cmd,
    input  logic [CW-1:0] count,
    input  logic [KW-1:0] req_key,
    input  logic [VW-1:0] req_value,
    input  logic [KW-1:0] next_key,
    input  logic [VW-1:0] next_value,
    input  logic          hit_in,
    output logic          hit_out,
    output logic          match,
    output logic [KW-1:0] key,
    output logic [VW-1:0] value
);

    logic [KW-1:0] key_reg;
    logic [VW-1:0] value_reg;
    logic          occupied;
    logic          is_tail;

    assign occupied = CW'(INDEX) < count;
    assign is_tail  = CW'(INDEX) == count;
    assign match    = occupied && (key_reg == req_key);
    // Hit ripples down the row: every cell at or after the match sees it.
    assign hit_out  = hit_in | match;
    assign key      = key_reg;
    assign value    = value_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.do_insert && is_tail)
        begin
            key_reg   <= req_key;
            value_reg <= req_value;
        end
        else if (cmd.do_remove && hit_out)
        begin
            // close the gap: take the neighbor's entry
            key_reg   <= next_key;
            value_reg <= next_value;
        end
    end

endmodule

// File: design/okvt_checker.sv
// Port-level checks for the ordered key-value table, bound to the top level.
module okvt_checker
    import okvt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic                found,
    input logic [KEY_W-1:0]    key_out,
    input logic [VALUE_W-1:0]  value_out,
    input logic [COUNT_W-1:0]  entry_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("response dropped while stalled");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in flight");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == ST_DONE)
        else $error("found reported with a failing status");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> !found && key_out == '0 && value_out == '0)
        else $error("failed request carries data");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CAPACITY > 31) || (int'(entry_count) <= CAPACITY))
        else $error("entry count beyond capacity");

endmodule

bind ordered_key_value_table_core okvt_checker #(.CAPACITY(CAPACITY)) u_okvt_checker (.*);
